FILE: src/mpmc_pkg.sv
// Shared types and constants for the multi-pattern match counter.
`default_nettype none
package mpmc_pkg;

    localparam int WEIGHT_W = 10;
    localparam int COUNT_W  = 32;

    // Command codes carried on the input cmd field
    typedef enum logic [1:0] {
        CMD_GOTO = 2'd0,
        CMD_NODE = 2'd1,
        CMD_SCAN = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // Scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE,
        ST_LINK,
        ST_WEIGHT
    } t_state;

    // Request from the sequencer to the count accumulator
    typedef struct packed {
        logic                add;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } t_acc_req;

endpackage
`default_nettype wire

FILE: src/multi_pattern_match_counter_core.sv
// Top level: Aho-Corasick digit matcher with goto and node record memories.
//
// Input channel (i_valid / o_ready) carries one command beat: cmd 0 writes a
// goto table entry, cmd 1 writes a node's failure link and weight, cmd 2 scans
// one digit, cmd 3 is dropped. Output channel (o_valid / i_ready) carries the
// match count of a string, one beat per scan beat marked last.
// Load beats write the memory when accepted. A scan beat makes one goto
// memory read, then for each failure link followed one node memory read and
// one goto memory read, both with registered read data, and the closing weight
// read is one more node memory read. A digit outside the alphabet skips the
// goto walk and reads the root's weight; a link chain cut off at the node count
// adds one more goto read from the root. The count beat is registered in the
// output register when the weight is added. Only one scan is in flight.
// The output register decouples the sides: the next scan proceeds while a
// count waits; a further last beat holds in its final state until the
// waiting count is taken.
// Reset puts the current node at the root and clears the count; the memory
// contents are not cleared and must be loaded before scanning.
`default_nettype none
module multi_pattern_match_counter_core #(
    parameter int NODES    = 131072,
    parameter int ALPHABET = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [16:0] i_node,
    input  wire logic [3:0]  i_digit,
    input  wire logic [16:0] i_target,
    input  wire logic [16:0] i_fail_link,
    input  wire logic [9:0]  i_weight,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_match_count
);

    localparam int NDW = $clog2(NODES);
    localparam int GAW = $clog2(NODES * ALPHABET);
    localparam int SW  = $clog2(NODES + 1);
    localparam int RW  = NDW + mpmc_pkg::WEIGHT_W;

    mpmc_pkg::t_state r_state, n_state;
    mpmc_pkg::t_cmd   w_cmd;

    logic [NDW-1:0] r_cur, n_cur;
    logic [NDW-1:0] r_walk, n_walk;
    logic [SW-1:0]  r_steps, n_steps;
    logic [3:0]     r_sym, n_sym;
    logic           r_last, n_last;

    logic           w_accept, w_scan_go, w_sym_ok, w_node_ok;
    logic           w_no_edge, w_steps_done, w_acc_go, w_out_free;
    logic [31:0]    w_node_x, w_target_x, w_link_x;

    // memory ports
    logic           g_we, g_re;
    logic [GAW-1:0] g_waddr, g_raddr;
    logic [NDW-1:0] g_wdata, g_rdata;
    logic [NDW-1:0] ga_node;
    logic [3:0]     ga_sym;
    logic           nr_we, nr_re;
    logic [NDW-1:0] nr_raddr;
    logic [RW-1:0]  nr_wdata, nr_rdata;
    logic [NDW-1:0] w_fail;

    mpmc_pkg::t_acc_req acc_req;

    // input decode
    assign w_cmd        = mpmc_pkg::t_cmd'(i_cmd);
    assign w_accept     = i_valid && o_ready;
    assign w_scan_go    = w_accept && (w_cmd == mpmc_pkg::CMD_SCAN);
    assign w_node_x     = 32'(i_node);
    assign w_target_x   = 32'(i_target);
    assign w_link_x     = 32'(i_fail_link);
    assign w_node_ok    = w_node_x < 32'(NODES);
    assign w_sym_ok     = 32'(i_digit) < 32'(ALPHABET);
    assign w_no_edge    = (r_walk != '0) && (g_rdata == '0);
    assign w_steps_done = 32'(r_steps) >= 32'(NODES);
    assign w_acc_go     = !r_last || w_out_free;
    assign w_fail       = nr_rdata[RW-1:mpmc_pkg::WEIGHT_W];
    assign o_ready      = (r_state == mpmc_pkg::ST_IDLE);

    // load writes
    assign g_we     = w_accept && (w_cmd == mpmc_pkg::CMD_GOTO) && w_node_ok && w_sym_ok;
    assign g_waddr  = GAW'(w_node_x * 32'(ALPHABET) + 32'(i_digit));
    assign g_wdata  = (w_target_x < 32'(NODES)) ? w_target_x[NDW-1:0] : '0;
    assign nr_we    = w_accept && (w_cmd == mpmc_pkg::CMD_NODE) && w_node_ok;
    assign nr_wdata = {((w_link_x < 32'(NODES)) ? w_link_x[NDW-1:0] : {NDW{1'b0}}),
                       i_weight};
    assign g_raddr  = GAW'(32'(ga_node) * 32'(ALPHABET) + 32'(ga_sym));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpmc_pkg::ST_IDLE: begin
                if (w_scan_go) begin
                    n_state = w_sym_ok ? mpmc_pkg::ST_EDGE : mpmc_pkg::ST_WEIGHT;
                end
            end
            mpmc_pkg::ST_EDGE: begin
                if (!w_no_edge) begin
                    n_state = mpmc_pkg::ST_WEIGHT;
                end else if (!w_steps_done) begin
                    n_state = mpmc_pkg::ST_LINK;
                end
            end
            mpmc_pkg::ST_LINK: begin
                n_state = mpmc_pkg::ST_EDGE;
            end
            mpmc_pkg::ST_WEIGHT: begin
                if (w_acc_go) begin
                    n_state = mpmc_pkg::ST_IDLE;
                end
            end
            default: n_state = mpmc_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: memory reads, walk registers, accumulate request
    always_comb begin
        g_re     = 1'b0;
        ga_node  = r_walk;
        ga_sym   = r_sym;
        nr_re    = 1'b0;
        nr_raddr = r_walk;
        n_walk   = r_walk;
        n_steps  = r_steps;
        n_sym    = r_sym;
        n_last   = r_last;
        n_cur    = r_cur;
        acc_req  = '{add: 1'b0, weight: nr_rdata[mpmc_pkg::WEIGHT_W-1:0], last: r_last};
        unique case (r_state)
            mpmc_pkg::ST_IDLE: begin
                if (w_scan_go) begin
                    n_sym   = i_digit;
                    n_last  = i_last;
                    n_steps = '0;
                    if (w_sym_ok) begin
                        g_re    = 1'b1;
                        ga_node = r_cur;
                        ga_sym  = i_digit;
                        n_walk  = r_cur;
                    end else begin
                        // no edge for this symbol anywhere: land on the root
                        n_walk   = '0;
                        nr_re    = 1'b1;
                        nr_raddr = '0;
                    end
                end
            end
            mpmc_pkg::ST_EDGE: begin
                if (!w_no_edge) begin
                    n_walk   = g_rdata;
                    nr_re    = 1'b1;
                    nr_raddr = g_rdata;
                end else if (w_steps_done) begin
                    // link chain too long: retry from the root
                    n_walk  = '0;
                    g_re    = 1'b1;
                    ga_node = '0;
                end else begin
                    nr_re    = 1'b1;
                    nr_raddr = r_walk;
                end
            end
            mpmc_pkg::ST_LINK: begin
                n_walk  = w_fail;
                n_steps = r_steps + SW'(1);
                g_re    = 1'b1;
                ga_node = w_fail;
            end
            mpmc_pkg::ST_WEIGHT: begin
                if (w_acc_go) begin
                    acc_req.add = 1'b1;
                    n_cur       = r_last ? '0 : r_walk;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpmc_pkg::ST_IDLE;
            r_cur   <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
        end
    end

    // walk payload registers
    always_ff @(posedge i_clk) begin
        r_walk  <= n_walk;
        r_steps <= n_steps;
        r_sym   <= n_sym;
        r_last  <= n_last;
    end

    mpmc_ram #(
        .DEPTH (NODES * ALPHABET),
        .WIDTH (NDW)
    ) u_goto_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_re    (g_re),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    mpmc_ram #(
        .DEPTH (NODES),
        .WIDTH (RW)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nr_we),
        .i_waddr (w_node_x[NDW-1:0]),
        .i_wdata (nr_wdata),
        .i_re    (nr_re),
        .i_raddr (nr_raddr),
        .o_rdata (nr_rdata)
    );

    mpmc_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (acc_req),
        .o_out_free    (w_out_free),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_match_count (o_match_count)
    );

    // a link step only follows an edge miss on a non-root node
    a_link_after_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mpmc_pkg::ST_LINK |-> $past(r_state) == mpmc_pkg::ST_EDGE
                                         && $past(r_walk) != '0)
        else $error("link step without a preceding edge miss");

    // the walk step count never passes the node count
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mpmc_pkg::ST_EDGE |-> 32'(r_steps) <= 32'(NODES))
        else $error("failure walk exceeded node bound");

    // the two memories are never read in the same cycle
    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(g_re && nr_re))
        else $error("goto and node memory read together");

    // a last beat is never added while a count still waits unaccepted
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_req.add && acc_req.last |-> !o_valid || i_ready)
        else $error("pending count overwritten");

    // writes only happen while no scan is in flight
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (g_we || nr_we) |-> r_state == mpmc_pkg::ST_IDLE && !g_re && !nr_re)
        else $error("memory write during scan");

endmodule
`default_nettype wire

FILE: src/mpmc_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module mpmc_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: src/mpmc_accum.sv
// Saturating match count accumulator and result output register.
`default_nettype none
module mpmc_accum (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mpmc_pkg::t_acc_req             i_req,
    output logic                                o_out_free,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [mpmc_pkg::COUNT_W-1:0]        o_match_count
);

    logic [mpmc_pkg::COUNT_W-1:0] r_count;
    logic [mpmc_pkg::COUNT_W-1:0] r_out;
    logic                         r_out_valid;
    logic [mpmc_pkg::COUNT_W:0]   w_sum;
    logic [mpmc_pkg::COUNT_W-1:0] w_sat;

    // add with clamp at all ones
    assign w_sum = {1'b0, r_count}
                 + {{(mpmc_pkg::COUNT_W + 1 - mpmc_pkg::WEIGHT_W){1'b0}}, i_req.weight};
    assign w_sat = w_sum[mpmc_pkg::COUNT_W] ? {mpmc_pkg::COUNT_W{1'b1}}
                                            : w_sum[mpmc_pkg::COUNT_W-1:0];

    assign o_out_free = !r_out_valid || i_ready;

    // running count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_req.add) begin
            r_count <= i_req.last ? '0 : w_sat;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_req.add && i_req.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.add && i_req.last) begin
            r_out <= w_sat;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_match_count = r_out;

endmodule
`default_nettype wire
